// File: rtl/ppt_pkg.sv
package ppt_pkg;

  // Coefficients are fixed signed 16-bit values, three to a 48-bit register.
  localparam int COEF_BITS    = 16;
  localparam int CFG_WIDTH    = 3 * COEF_BITS;
  localparam int CFG_IDX_BITS = 2;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // Identity matrix in Q8.8.
  localparam logic [CFG_WIDTH-1:0] ROW_X_RESET = 48'h0000_0000_0100;
  localparam logic [CFG_WIDTH-1:0] ROW_Y_RESET = 48'h0000_0100_0000;
  localparam logic [CFG_WIDTH-1:0] ROW_W_RESET = 48'h0100_0000_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_W = 2'd2
  } ppt_reg_e;

  // Side information that travels with one quotient through the divider.
  typedef struct packed {
    logic neg;    // quotient is negative
    logic ovf;    // integer part already too large for the output
    logic dzero;  // divisor was zero
    logic npos;   // numerator positive
    logic nneg;   // numerator negative
  } ppt_flags_t;

  // Width of an exact dot product: two coefficient by coordinate products and
  // one coefficient scaled by the fraction, plus growth for the two adds.
  function automatic int ppt_dot_width(input int cw, input int fb);
    int m;
    m = (cw > fb) ? cw : fb;
    return COEF_BITS + m + 2;
  endfunction

endpackage

// File: rtl/ppt_dot.sv
module ppt_dot import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int DW = ppt_dot_width(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                          clk_i,
  input  logic [CFG_WIDTH-1:0]          coef_i,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  output logic signed [DW-1:0]          dot_o
);

  localparam int PW = COEF_BITS + COORD_WIDTH;

  logic signed [COEF_BITS-1:0] c0, c1, c2;
  logic signed [PW-1:0]        p0_d, p1_d;
  logic signed [PW-1:0]        p0_q, p1_q;
  logic signed [COEF_BITS-1:0] c2_q;
  logic signed [DW-1:0]        s0, s1, s2;
  logic signed [DW-1:0]        dot_q;

  assign c0 = coef_i[COEF_BITS-1:0];
  assign c1 = coef_i[2*COEF_BITS-1:COEF_BITS];
  assign c2 = coef_i[3*COEF_BITS-1:2*COEF_BITS];

  assign p0_d = PW'(c0) * PW'(x_i);
  assign p1_d = PW'(c1) * PW'(y_i);

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
    c2_q <= c2;
  end

  // The constant term multiplies the homogeneous 1, which sits at FRAC_BITS.
  assign s0 = DW'(p0_q);
  assign s1 = DW'(p1_q);
  assign s2 = DW'(c2_q) <<< FRAC_BITS;

  always_ff @(posedge clk_i) begin
    dot_q <= s0 + s1 + s2;
  end

  assign dot_o = dot_q;

endmodule

// File: rtl/ppt_div_cell.sv
module ppt_div_cell import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int DW = ppt_dot_width(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                   clk_i,
  input  logic [DW-1:0]          rem_i,
  input  logic [DW-1:0]          den_i,
  input  logic [COORD_WIDTH-1:0] low_i,
  input  logic [COORD_WIDTH-1:0] quo_i,
  input  ppt_flags_t             flags_i,
  output logic [DW-1:0]          rem_o,
  output logic [DW-1:0]          den_o,
  output logic [COORD_WIDTH-1:0] low_o,
  output logic [COORD_WIDTH-1:0] quo_o,
  output ppt_flags_t             flags_o
);

  logic [DW:0]   trial;
  logic [DW:0]   den_ext;
  logic          fits;
  logic [DW:0]   rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial    = {rem_i, low_i[COORD_WIDTH-1]};
  assign den_ext  = {1'b0, den_i};
  assign fits     = (trial >= den_ext);
  assign rem_next = fits ? (trial - den_ext) : trial;

  always_ff @(posedge clk_i) begin
    rem_o   <= rem_next[DW-1:0];
    den_o   <= den_i;
    low_o   <= low_i << 1;
    quo_o   <= {quo_i[COORD_WIDTH-2:0], fits};
    flags_o <= flags_i;
  end

endmodule

// File: rtl/ppt_div_lane.sv
module ppt_div_lane import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int DW = ppt_dot_width(COORD_WIDTH, FRAC_BITS)
) (
  input  logic                          clk_i,
  input  logic signed [DW-1:0]          num_i,
  input  logic signed [DW-1:0]          den_i,
  output logic signed [COORD_WIDTH-1:0] res_o,
  output logic                          sat_o,
  output logic                          zero_o
);

  localparam int NW   = DW + FRAC_BITS;
  localparam int HW   = NW - COORD_WIDTH;
  localparam int CMPW = (HW > DW) ? HW : DW;

  localparam logic [COORD_WIDTH-1:0] NEG_LIM = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
  localparam logic [COORD_WIDTH-1:0] POS_LIM = NEG_LIM - COORD_WIDTH'(1);

  // Sign and magnitude.
  logic [DW-1:0] un_d, ud_d;
  logic [DW-1:0] un_q, ud_q;
  ppt_flags_t    fl1_d, fl1_q;

  assign un_d = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
  assign ud_d = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);

  always_comb begin
    fl1_d       = '0;
    fl1_d.neg   = num_i[DW-1] ^ den_i[DW-1];
    fl1_d.dzero = (den_i == '0);
    fl1_d.npos  = !num_i[DW-1] && (num_i != '0);
    fl1_d.nneg  = num_i[DW-1];
  end

  always_ff @(posedge clk_i) begin
    un_q  <= un_d;
    ud_q  <= ud_d;
    fl1_q <= fl1_d;
  end

  // The scaled dividend splits into a high part, checked against the divisor
  // for overflow, and COORD_WIDTH low bits that the cells bring down one by one.
  logic [NW-1:0]   dvd;
  logic [HW-1:0]   hi;
  ppt_flags_t      fl2_d;

  logic [DW-1:0]          rem_w   [COORD_WIDTH+1];
  logic [DW-1:0]          den_w   [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] low_w   [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] quo_w   [COORD_WIDTH+1];
  ppt_flags_t             flags_w [COORD_WIDTH+1];

  assign dvd = NW'(un_q) << FRAC_BITS;
  assign hi  = dvd[NW-1:COORD_WIDTH];

  always_comb begin
    fl2_d     = fl1_q;
    fl2_d.ovf = (CMPW'(hi) >= CMPW'(ud_q));
  end

  always_ff @(posedge clk_i) begin
    rem_w[0]   <= DW'(hi);
    den_w[0]   <= ud_q;
    low_w[0]   <= dvd[COORD_WIDTH-1:0];
    quo_w[0]   <= '0;
    flags_w[0] <= fl2_d;
  end

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_cell
    ppt_div_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (rem_w[k]),
      .den_i  (den_w[k]),
      .low_i  (low_w[k]),
      .quo_i  (quo_w[k]),
      .flags_i(flags_w[k]),
      .rem_o  (rem_w[k+1]),
      .den_o  (den_w[k+1]),
      .low_o  (low_w[k+1]),
      .quo_o  (quo_w[k+1]),
      .flags_o(flags_w[k+1])
    );
  end

  // Clip, apply the sign, and handle a zero divisor.
  ppt_flags_t             fl_end;
  logic [COORD_WIDTH-1:0] q_end;
  logic [COORD_WIDTH-1:0] lim;
  logic                   clip;
  logic [COORD_WIDTH-1:0] mag;
  logic [COORD_WIDTH-1:0] res_d;
  logic                   sat_d;

  assign fl_end = flags_w[COORD_WIDTH];
  assign q_end  = quo_w[COORD_WIDTH];
  assign lim    = fl_end.neg ? NEG_LIM : POS_LIM;
  assign clip   = fl_end.ovf || (q_end > lim);
  assign mag    = clip ? lim : q_end;

  always_comb begin
    if (fl_end.dzero) begin
      sat_d = 1'b0;
      if (fl_end.npos) begin
        res_d = POS_LIM;
      end else if (fl_end.nneg) begin
        res_d = NEG_LIM;
      end else begin
        res_d = '0;
      end
    end else begin
      sat_d = clip;
      res_d = fl_end.neg ? (COORD_WIDTH'(0) - mag) : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o  <= res_d;
    sat_o  <= sat_d;
    zero_o <= fl_end.dzero;
  end

endmodule

// File: rtl/projective_point_transform_top.sv
// Projective point transform: each word (x_in, y_in) is multiplied through a
// 3x3 matrix held in the three row registers, and the block returns x/z and
// y/z in the input format, saturated, with flags for clipping and for a zero
// divisor. A new word is taken on every clock (busy_o stays low), and its
// result reaches done_o through the product and sum registers, the
// magnitude and dividend-split registers, one divider cell per quotient
// bit, and one output register. Results are shown for one cycle only and
// are not held, so the receiver must take them as they come.
// Write the row registers only when no word is in flight.
module projective_point_transform_top import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] x_in_i,
  input  logic signed [COORD_WIDTH-1:0] y_in_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]          cfg_wdata_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] x_out_o,
  output logic signed [COORD_WIDTH-1:0] y_out_o,
  output logic                          zero_divisor_o,
  output logic                          saturated_o
);

  localparam int DW  = ppt_dot_width(COORD_WIDTH, FRAC_BITS);
  localparam int LAT = COORD_WIDTH + 5;

  logic [CFG_WIDTH-1:0] row_x_coeffs_q, row_y_coeffs_q, row_w_coeffs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_coeffs_q <= ROW_X_RESET;
      row_y_coeffs_q <= ROW_Y_RESET;
      row_w_coeffs_q <= ROW_W_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_X: row_x_coeffs_q <= cfg_wdata_i;
        REG_ROW_Y: row_y_coeffs_q <= cfg_wdata_i;
        REG_ROW_W: row_w_coeffs_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic [LAT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], start_i && !busy_o};
    end
  end

  logic signed [DW-1:0] xh, yh, zh;

  ppt_dot #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot_x (
    .clk_i (clk_i),
    .coef_i(row_x_coeffs_q),
    .x_i   (x_in_i),
    .y_i   (y_in_i),
    .dot_o (xh)
  );

  ppt_dot #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot_y (
    .clk_i (clk_i),
    .coef_i(row_y_coeffs_q),
    .x_i   (x_in_i),
    .y_i   (y_in_i),
    .dot_o (yh)
  );

  ppt_dot #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot_w (
    .clk_i (clk_i),
    .coef_i(row_w_coeffs_q),
    .x_i   (x_in_i),
    .y_i   (y_in_i),
    .dot_o (zh)
  );

  logic x_sat, y_sat, x_zero, y_zero;

  ppt_div_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .num_i (xh),
    .den_i (zh),
    .res_o (x_out_o),
    .sat_o (x_sat),
    .zero_o(x_zero)
  );

  ppt_div_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .num_i (yh),
    .den_i (zh),
    .res_o (y_out_o),
    .sat_o (y_sat),
    .zero_o(y_zero)
  );

  // Both lanes see the same divisor, so their zero flags agree.
  assign zero_divisor_o = x_zero && y_zero;
  assign saturated_o    = x_sat || y_sat;
  assign done_o         = valid_q[LAT-1];

endmodule

// File: tb/ppt_checker.sv
`timescale 1ns / 1ps

// Watches the word and result channels of the point transform. It keeps its
// own copy of the three matrix rows, predicts x/z and y/z for each accepted
// word, and compares every result with the oldest prediction.
module ppt_checker import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [COORD_WIDTH-1:0] x_in_i,
  input  logic signed [COORD_WIDTH-1:0] y_in_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]          cfg_wdata_i,
  input  logic                          done_i,
  input  logic signed [COORD_WIDTH-1:0] x_out_i,
  input  logic signed [COORD_WIDTH-1:0] y_out_i,
  input  logic                          zero_divisor_i,
  input  logic                          saturated_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   results_owed_o
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t x_out;
    coord_t y_out;
    logic   zero_div;
    logic   clipped;
  } point_result_t;

  logic [CFG_WIDTH-1:0] row_x;
  logic [CFG_WIDTH-1:0] row_y;
  logic [CFG_WIDTH-1:0] row_w;
  point_result_t        owed_points[$];

  // Exact dot product of one row with (x, y, 1); the result carries
  // 2*FRAC_BITS fraction bits.
  function automatic longint row_sum(input logic [CFG_WIDTH-1:0] row,
                                     input coord_t px, input coord_t py);
    logic signed [COEF_BITS-1:0] c0, c1, c2;
    c0 = row[COEF_BITS-1:0];
    c1 = row[2*COEF_BITS-1:COEF_BITS];
    c2 = row[3*COEF_BITS-1:2*COEF_BITS];
    return longint'(c0) * longint'(px) + longint'(c1) * longint'(py)
           + longint'(c2) * (longint'(1) << FRAC_BITS);
  endfunction

  // Quotient truncated toward zero, clipped to the coordinate range.
  function automatic coord_t scaled_quotient(input longint num, input longint den,
                                             inout logic clipped);
    longint mag_n, mag_d, q, lim;
    logic   neg;
    neg   = (num < 0) != (den < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    lim   = neg ? (longint'(1) << (COORD_WIDTH - 1))
                : (longint'(1) << (COORD_WIDTH - 1)) - 1;
    if (mag_n == 0) return '0;
    q = (mag_n << FRAC_BITS) / mag_d;
    if (q > lim) begin
      clipped = 1'b1;
      q = lim;
    end
    q = neg ? -q : q;
    return q[COORD_WIDTH-1:0];
  endfunction

  // With a zero divisor each output goes to the limit that matches the sign
  // of its numerator.
  function automatic coord_t limit_for_sign(input longint num);
    if (num > 0) return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    if (num < 0) return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    return '0;
  endfunction

  function automatic point_result_t project_point(input coord_t px, input coord_t py);
    point_result_t r;
    longint        xh, yh, zh;
    logic          clipped;
    xh = row_sum(row_x, px, py);
    yh = row_sum(row_y, px, py);
    zh = row_sum(row_w, px, py);
    clipped = 1'b0;
    if (zh == 0) begin
      r.x_out    = limit_for_sign(xh);
      r.y_out    = limit_for_sign(yh);
      r.zero_div = 1'b1;
      r.clipped  = 1'b0;
    end else begin
      r.x_out    = scaled_quotient(xh, zh, clipped);
      r.y_out    = scaled_quotient(yh, zh, clipped);
      r.zero_div = 1'b0;
      r.clipped  = clipped;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    point_result_t want;
    if (!rst_ni) begin
      row_x = ROW_X_RESET;
      row_y = ROW_Y_RESET;
      row_w = ROW_W_RESET;
      owed_points.delete();
      mismatch_count_o = 0;
    end else begin
      // Results are retired before the new word is queued.
      if (done_i) begin
        if (owed_points.size() == 0) begin
          $error("result with no word outstanding: x_out %0d y_out %0d", x_out_i, y_out_i);
          mismatch_count_o++;
        end else begin
          want = owed_points.pop_front();
          if (x_out_i !== want.x_out) begin
            $error("x_out: expected %0d, got %0d", want.x_out, x_out_i);
            mismatch_count_o++;
          end
          if (y_out_i !== want.y_out) begin
            $error("y_out: expected %0d, got %0d", want.y_out, y_out_i);
            mismatch_count_o++;
          end
          if (zero_divisor_i !== want.zero_div) begin
            $error("zero_divisor: expected %0b, got %0b", want.zero_div, zero_divisor_i);
            mismatch_count_o++;
          end
          if (saturated_i !== want.clipped) begin
            $error("saturated: expected %0b, got %0b", want.clipped, saturated_i);
            mismatch_count_o++;
          end
        end
      end
      if (start_i && busy_i === 1'b0) owed_points.push_back(project_point(x_in_i, y_in_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ROW_X: row_x = cfg_wdata_i;
          REG_ROW_Y: row_y = cfg_wdata_i;
          REG_ROW_W: row_w = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    results_owed_o = owed_points.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ppt_pkg::*;

  localparam int COORD_WIDTH     = COORD_WIDTH_DEF;
  localparam int FRAC_BITS       = FRAC_BITS_DEF;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int WATCHDOG_LIMIT  = 2000;

  // The index that no register answers to; writes there must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam logic [CFG_WIDTH-1:0] ROW_X_UNIT = 48'h0000_0000_0100;
  localparam logic [CFG_WIDTH-1:0] ROW_Y_UNIT = 48'h0000_0100_0000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  coord_t               x_in = '0;
  coord_t               y_in = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  logic                 done;
  coord_t               x_out;
  coord_t               y_out;
  logic                 zero_divisor;
  logic                 saturated;
  int unsigned          mismatch_count;
  int unsigned          results_owed;
  int unsigned          quiet_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  projective_point_transform_top #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .x_in_i        (x_in),
    .y_in_i        (y_in),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .done_o        (done),
    .x_out_o       (x_out),
    .y_out_o       (y_out),
    .zero_divisor_o(zero_divisor),
    .saturated_o   (saturated)
  );

  ppt_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .x_in_i          (x_in),
    .y_in_i          (y_in),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .done_i          (done),
    .x_out_i         (x_out),
    .y_out_i         (y_out),
    .zero_divisor_i  (zero_divisor),
    .saturated_i     (saturated),
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed)
  );

  // Ends the run if neither a word nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(input coord_t px, input coord_t py);
    @(negedge clk);
    start = 1'b1;
    x_in  = px;
    y_in  = py;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(input int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic await_results();
    @(negedge clk);
    start = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_matrix(input logic [CFG_WIDTH-1:0] rx, input logic [CFG_WIDTH-1:0] ry,
                             input logic [CFG_WIDTH-1:0] rw);
    await_results();
    set_reg(REG_ROW_X, rx);
    set_reg(REG_ROW_Y, ry);
    set_reg(REG_ROW_W, rw);
  endtask

  // Mostly small coefficients so that quotients stay in range, with the
  // extremes and fully random codes mixed in.
  function automatic logic [COEF_BITS-1:0] pick_coef();
    logic [COEF_BITS-1:0] c;
    case ($urandom_range(0, 9))
      0: c = 16'h7FFF;
      1: c = 16'h8000;
      2: c = '0;
      3, 4: c = COEF_BITS'($urandom);
      default: c = COEF_BITS'($urandom_range(0, 1024) - 512);
    endcase
    return c;
  endfunction

  function automatic logic [CFG_WIDTH-1:0] pick_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic coord_t pick_coord();
    coord_t c;
    case ($urandom_range(0, 7))
      0, 1: c = coord_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: c = 16'h7FFF;
          1: c = 16'h8000;
          2: c = '0;
          default: c = 16'hFFFF;
        endcase
      end
      default: c = coord_t'($urandom_range(0, 8191) - 4096);
    endcase
    return c;
  endfunction

  initial begin
    logic [CFG_WIDTH-1:0]        rx, ry, rw;
    logic signed [COEF_BITS-1:0] aim_c2;
    coord_t                      px, py;
    logic                        quiet;

    aim_c2 = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Identity matrix from reset: every point comes back unchanged.
    send_point(16'sh0000, 16'sh0000);
    send_point(16'sh7FFF, 16'sh8000);
    send_point(16'sh8000, 16'sh7FFF);
    send_point(16'shFFFF, 16'sh0001);
    send_point(16'sh5555, 16'shAAAA);
    send_point(16'shAAAA, 16'sh5555);

    // Zero divisor: outputs follow the sign of their numerators.
    load_matrix(ROW_X_UNIT, ROW_Y_UNIT, '0);
    send_point(16'sh0005, 16'shFFFD);
    send_point(16'sh0000, 16'sh0000);
    send_point(16'shFFF9, 16'sh0009);

    // Divisor of one code step scales by 256, so codes outside -128 to 127 clip.
    load_matrix(ROW_X_UNIT, ROW_Y_UNIT, 48'h0001_0000_0000);
    send_point(16'sh7FFF, 16'sh8000);
    send_point(16'sh007F, 16'shFF80);
    send_point(16'sh0080, 16'shFF7F);
    send_point(16'sh0000, 16'sh0000);

    // Divisor of -1.0: negating the smallest code overflows.
    load_matrix(ROW_X_UNIT, ROW_Y_UNIT, 48'hFF00_0000_0000);
    send_point(16'sh8000, 16'sh0005);
    send_point(16'sh7FFF, 16'shFFFF);

    // Divisor of 3.0 checks truncation toward zero; the spare index write
    // after it must leave the matrix alone.
    load_matrix(ROW_X_UNIT, ROW_Y_UNIT, 48'h0300_0000_0000);
    set_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);
    send_point(16'sh0001, 16'shFFFF);
    send_point(16'sh8000, 16'sh7FFF);
    send_point(16'sh0007, 16'shFFF9);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          rx = {3{16'h7FFF}};
          ry = rx;
          rw = rx;
        end
        1: begin
          rx = {3{16'h8000}};
          ry = rx;
          rw = rx;
        end
        2: begin
          rx = '0;
          ry = '0;
          rw = '0;
        end
        3: begin
          // Divisor is x + c2, which some points are aimed to cancel.
          aim_c2 = COEF_BITS'($urandom_range(0, 4000) - 2000);
          rx = pick_row();
          ry = pick_row();
          rw = {aim_c2, 16'h0000, 16'h0100};
        end
        default: begin
          rx = pick_row();
          ry = pick_row();
          if ($urandom_range(0, 3) == 0) begin
            rw = pick_row();
          end else begin
            rw[15:0]  = COEF_BITS'($urandom_range(0, 128) - 64);
            rw[31:16] = COEF_BITS'($urandom_range(0, 128) - 64);
            rw[47:32] = COEF_BITS'(16'h0100 + $urandom_range(0, 512) - 256);
          end
        end
      endcase
      load_matrix(rx, ry, rw);
      if ($urandom_range(0, 2) == 0) set_reg(REG_SPARE, CFG_WIDTH'({$urandom, $urandom}));
      quiet = (p >= RAND_PHASES - 2) || (p % 4 == 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        px = pick_coord();
        py = pick_coord();
        if (p == 3 && $urandom_range(0, 2) == 0) px = -aim_c2;
        send_point(px, py);
        if (p == 5 && i == ITEMS_PER_PHASE / 2) begin
          await_results();
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          pause($urandom_range(1, 10));
        end
      end
    end

    await_results();
    repeat (COORD_WIDTH + 10) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ppt_pkg.sv
rtl/ppt_dot.sv
rtl/ppt_div_cell.sv
rtl/ppt_div_lane.sv
rtl/projective_point_transform_top.sv
tb/ppt_checker.sv
tb/tb_top.sv
